/* rtl/awlr_pkg.sv */
// ----------------------------------------------------------------------------
// awlr_pkg
// shared types and constants of the alpha-weighted linear resampler
// ----------------------------------------------------------------------------
package awlr_pkg;

  localparam int STEP_W  = 24;
  localparam int IDX_W   = 12;
  localparam int PIX_W   = 16;
  localparam int ALPHA_W = 13;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = 42;
  localparam int WT_W    = 18;
  localparam int NUM_W   = 36;
  localparam int DEN_W   = 19;

  localparam logic [0:0] OP_WRITE   = 1'b0;
  localparam logic [0:0] OP_REQUEST = 1'b1;

  localparam logic [0:0] REG_STEP = 1'b0;
  localparam logic [0:0] REG_LAST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WEIGHT,
    ST_PRODUCT,
    ST_DIVIDE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

/* rtl/alpha_weighted_linear_resample_core.sv */
// ----------------------------------------------------------------------------
// alpha_weighted_linear_resample_core
// alpha-weighted linear resampler for one line of Y/Cb/Cr/alpha pixels
// ----------------------------------------------------------------------------
// A write word (op 0) stores a pixel in the line memory and does not stall
// the input. A request word (op 1) reads its two neighbors from the
// dual-read line memory, weights them by alpha and the fraction, and divides
// the three weighted sums in a shared bit-serial divider of 36 steps; when
// the summed weight is zero the divide is skipped. The next word is taken
// once the result has been moved to the output register. The line memory
// has no reset; only written entries may be read.
module alpha_weighted_linear_resample_core
  import awlr_pkg::*;
#(
  parameter int LINE_DEPTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [IDX_W-1:0]          index,
  input  logic signed [PIX_W-1:0]   luma_in,
  input  logic signed [PIX_W-1:0]   blue_diff_in,
  input  logic signed [PIX_W-1:0]   red_diff_in,
  input  logic [ALPHA_W-1:0]        alpha_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PIX_W-1:0]   luma_out,
  output logic signed [PIX_W-1:0]   blue_diff_out,
  output logic signed [PIX_W-1:0]   red_diff_out,
  output logic [ALPHA_W-1:0]        alpha_out
);

  localparam int AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int ENT_W = 3 * PIX_W + ALPHA_W;
  localparam int CW    = (AW > IDX_W) ? AW : IDX_W;

  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  last_source_index;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step              <= STEP_W'(24'h10000);
      last_source_index <= '1;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_STEP: step              <= pwdata[STEP_W-1:0];
        REG_LAST: last_source_index <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_STEP: prdata = 32'(step);
        REG_LAST: prdata = 32'(last_source_index);
        default: ;
      endcase
    end
  end

  // line memory
  logic [ENT_W-1:0] line_mem [LINE_DEPTH];
  logic [ENT_W-1:0] rd0, rd1;
  logic [AW-1:0]    ra0, ra1;

  state_t state, state_next;
  logic   accept;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept && op == OP_WRITE && 32'(index) < LINE_DEPTH)
      line_mem[AW'(index)] <= {luma_in, blue_diff_in, red_diff_in, alpha_in};
    rd0 <= line_mem[ra0];
    rd1 <= line_mem[ra1];
  end

  // position
  logic [IDX_W-1:0] req_idx;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] prod;
  logic [STEP_W-1:0] half;
  logic [FRAC_W:0]  frac, inv;

  assign prod = POS_W'(step) * POS_W'(req_idx);
  assign half = (step >= STEP_W'(24'h10000)) ? ((step - STEP_W'(24'h10000)) >> 1)
                                              : ((STEP_W'(24'h10000) - step) >> 1);
  assign pos_next = (step >= STEP_W'(24'h10000))
                    ? prod + POS_W'(32'h10000) + POS_W'(half)
                    : prod + POS_W'(32'h10000) - POS_W'(half);

  logic [POS_W-FRAC_W-1:0] ipart;
  logic [CW-1:0] c0, c1;
  assign ipart = pos[POS_W-1:FRAC_W];

  function automatic logic [CW-1:0] clampk(input logic [POS_W-FRAC_W:0] k,
                                           input logic [IDX_W-1:0] lim);
    logic [POS_W-FRAC_W:0] r;
    begin
      r = k;
      if (r > (POS_W-FRAC_W+1)'(lim)) r = (POS_W-FRAC_W+1)'(lim);
      if (r > (POS_W-FRAC_W+1)'(LINE_DEPTH - 1)) r = (POS_W-FRAC_W+1)'(LINE_DEPTH - 1);
      return CW'(r);
    end
  endfunction

  // left = ipart - 1 (clamped at 0), right = ipart; both clamped to last_source_index and the line depth
  assign c0 = (ipart == '0) ? '0 : clampk({1'b0, ipart} - 1'b1, last_source_index);
  assign c1 = clampk({1'b0, ipart}, last_source_index);
  assign ra0 = AW'(c0);
  assign ra1 = AW'(c1);
  assign frac = {1'b0, pos[FRAC_W-1:0]};
  assign inv  = 17'h10000 - frac;

  // weights
  logic [WT_W-1:0] w0, w1;
  logic [DEN_W-1:0] wsum;
  logic signed [PIX_W-1:0] p0 [3];
  logic signed [PIX_W-1:0] p1 [3];
  logic signed [NUM_W-1:0] num [3];
  logic [PIX_W-1:0] quot [3];
  logic [ALPHA_W-1:0] a_res;
  div_ctrl_t dctl;
  logic dstart;

  logic [30:0] m0, m1;
  assign m0 = 31'(rd0[ALPHA_W-1:0]) * 31'(inv);
  assign m1 = 31'(rd1[ALPHA_W-1:0]) * 31'(frac);

  always_ff @(posedge clk) begin
    if (accept) req_idx <= index;
    if (state == ST_READ) pos <= pos_next;
    if (state == ST_WEIGHT) begin
      w0 <= WT_W'((m0 + 31'h800) >> 12);
      w1 <= WT_W'((m1 + 31'h800) >> 12);
      for (int l = 0; l < 3; l++) begin
        p0[l] <= rd0[ENT_W-1-l*PIX_W -: PIX_W];
        p1[l] <= rd1[ENT_W-1-l*PIX_W -: PIX_W];
      end
    end
    if (state == ST_PRODUCT) begin
      wsum  <= DEN_W'(w0) + DEN_W'(w1);
      a_res <= ALPHA_W'((DEN_W'(w0) + DEN_W'(w1) + DEN_W'(8)) >> 4);
      for (int l = 0; l < 3; l++)
        num[l] <= NUM_W'(p0[l]) * $signed({1'b0, w0}) + NUM_W'(p1[l]) * $signed({1'b0, w1});
    end
  end

  awlr_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(dstart),
    .num  (num),
    .den  (wsum),
    .ctrl (dctl),
    .quot (quot)
  );

  logic ostart;
  always_ff @(posedge clk) begin
    if (rst) ostart <= 1'b0;
    else     ostart <= (state == ST_PRODUCT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // rd_ok holds the weight state until it sees the read data of the registered position
  logic rd_ok;
  always_ff @(posedge clk) begin
    if (rst) rd_ok <= 1'b0;
    else     rd_ok <= (state == ST_WEIGHT) && !rd_ok;
  end

  always_comb begin
    state_next = state;
    dstart     = 1'b0;
    unique case (state)
      ST_IDLE:    if (accept && op == OP_REQUEST) state_next = ST_READ;
      ST_READ:    state_next = ST_WEIGHT;
      ST_WEIGHT:  if (rd_ok) state_next = ST_PRODUCT;
      ST_PRODUCT: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (ostart) begin
          if (wsum == '0) state_next = ST_OUT;
          else dstart = 1'b1;
        end else if (dctl.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT:     if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || !out_stall)) begin
      if (wsum == '0) begin
        luma_out      <= '0;
        blue_diff_out <= '0;
        red_diff_out  <= '0;
        alpha_out     <= '0;
      end else begin
        luma_out      <= quot[0];
        blue_diff_out <= quot[1];
        red_diff_out  <= quot[2];
        alpha_out     <= a_res;
      end
    end
  end

endmodule

/* rtl/awlr_divider.sv */
// ----------------------------------------------------------------------------
// awlr_divider
// three-lane radix-2 signed divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
module awlr_divider
  import awlr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num [3],
  input  logic        [DEN_W-1:0] den,
  output div_ctrl_t               ctrl,
  output logic        [PIX_W-1:0] quot [3]
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] mag [3];
  logic [DEN_W:0]   rem [3];
  logic             neg [3];
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [DEN_W:0] trial;
    assign trial = {rem[l][DEN_W-1:0], mag[l][NUM_W-1]};
    always_ff @(posedge clk) begin
      if (start) begin
        neg[l] <= num[l][NUM_W-1];
        mag[l] <= num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
        rem[l] <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dreg}) begin
          rem[l] <= trial - {1'b0, dreg};
          mag[l] <= {mag[l][NUM_W-2:0], 1'b1};
        end else begin
          rem[l] <= trial;
          mag[l] <= {mag[l][NUM_W-2:0], 1'b0};
        end
      end
    end
    assign quot[l] = neg[l] ? PIX_W'(-mag[l]) : mag[l][PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) dreg <= den;
  end

  assign ctrl = '{start: start, busy: busy, done: done};

endmodule

/* tb/tb_alpha_weighted_linear_resample_core.sv */
// ----------------------------------------------------------------------------
// tb_alpha_weighted_linear_resample_core
// self-checking bench for the alpha-weighted linear resampler
// ----------------------------------------------------------------------------
// Source pixels are written into the line memory, and output indexes are
// requested under several step and clamp settings. Every request word gets
// a predicted pixel from a local copy of the line and the registers, and
// each output word is compared with it field by field. Both channels
// idle at random, and at one point the output holds off for a long stretch.
// Requests are only issued once both of their neighbors have been written.
// ----------------------------------------------------------------------------
module tb_alpha_weighted_linear_resample_core;
  import awlr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 4096;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS = 300;

  typedef struct {
    bit signed [PIX_W-1:0] y;
    bit signed [PIX_W-1:0] cb;
    bit signed [PIX_W-1:0] cr;
    bit [ALPHA_W-1:0] a;
  } pixel_t;

  class resample_scoreboard;
    pixel_t line[DEPTH];
    bit written[DEPTH];
    int unsigned step_val;
    int unsigned last_val;
    pixel_t pending[$];

    function new();
      step_val = 65536;
      last_val = DEPTH - 1;
    endfunction

    function int unsigned clamp(longint k);
      if (k < 0) k = 0;
      if (k > longint'(last_val)) k = last_val;
      if (k > DEPTH - 1) k = DEPTH - 1;
      return 32'(k);
    endfunction

    function longint position(int unsigned idx);
      longint pos;
      pos = longint'(step_val) * idx + 65536;
      if (step_val >= 65536) pos += (step_val - 65536) >> 1;
      else pos -= (65536 - step_val) >> 1;
      return pos;
    endfunction

    function void neighbors(int unsigned idx, output int unsigned n0, output int unsigned n1);
      longint left;
      left = (position(idx) >> 16) - 1;
      n0 = clamp(left);
      n1 = clamp(left + 1);
    endfunction

    function void note(bit is_req, int unsigned idx, pixel_t p);
      longint pos, frac, inv, w0, w1, wsum, y, cb, cr;
      int unsigned n0, n1;
      pixel_t p0, p1, r;
      if (is_req == OP_WRITE) begin
        if (idx < DEPTH) begin
          line[idx] = p;
          written[idx] = 1;
        end
        return;
      end
      pos = position(idx);
      frac = pos & 64'hffff;
      inv = 65536 - frac;
      neighbors(idx, n0, n1);
      p0 = line[n0];
      p1 = line[n1];
      w0 = (longint'(p0.a) * inv + 2048) >> 12;
      w1 = (longint'(p1.a) * frac + 2048) >> 12;
      wsum = w0 + w1;
      if (wsum == 0) begin
        r.y = 0; r.cb = 0; r.cr = 0; r.a = 0;
      end else begin
        y = (longint'(p0.y) * w0 + longint'(p1.y) * w1) / wsum;
        cb = (longint'(p0.cb) * w0 + longint'(p1.cb) * w1) / wsum;
        cr = (longint'(p0.cr) * w0 + longint'(p1.cr) * w1) / wsum;
        r.y = y[PIX_W-1:0];
        r.cb = cb[PIX_W-1:0];
        r.cr = cr[PIX_W-1:0];
        r.a = 13'((wsum + 8) >> 4);
      end
      pending.push_back(r);
    endfunction

    // 0 matched, 1 some field differs, 2 nothing was expected
    function int check(pixel_t got, output pixel_t want);
      if (pending.size() == 0) return 2;
      want = pending.pop_front();
      if (got.y == want.y && got.cb == want.cb && got.cr == want.cr && got.a == want.a)
        return 0;
      return 1;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic op = OP_WRITE;
  logic [IDX_W-1:0] index = '0;
  logic signed [PIX_W-1:0] luma_in = '0, blue_diff_in = '0, red_diff_in = '0;
  logic [ALPHA_W-1:0] alpha_in = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [PIX_W-1:0] luma_out, blue_diff_out, red_diff_out;
  logic [ALPHA_W-1:0] alpha_out;

  resample_scoreboard sb = new();
  int errors = 0;
  int phase = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 88;
  int hold_left = 0;
  bit held = 0;
  int quiet_cycles = 0;
  int sent = 0;

  alpha_weighted_linear_resample_core dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    int verdict;
    if (!rst && out_valid && !out_stall) begin
      got.y = luma_out; got.cb = blue_diff_out; got.cr = red_diff_out; got.a = alpha_out;
      verdict = sb.check(got, want);
      if (verdict == 2) report("output word with no request pending");
      else if (verdict == 1) begin
        if (got.y != want.y) report($sformatf("luma %0d want %0d", got.y, want.y));
        if (got.cb != want.cb) report($sformatf("cb %0d want %0d", got.cb, want.cb));
        if (got.cr != want.cr) report($sformatf("cr %0d want %0d", got.cr, want.cr));
        if (got.a != want.a) report($sformatf("alpha %0d want %0d", got.a, want.a));
      end
    end
    if (!rst && in_valid && !in_stall) begin
      got.y = luma_in; got.cb = blue_diff_in; got.cr = red_diff_in; got.a = alpha_in;
      sb.note(op, index, got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_alpha_weighted_linear_resample_core failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(negedge clk) begin
    if (phase == 2 && !held) begin
      held <= 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.y = PIX_W'($urandom); p.cb = PIX_W'($urandom); p.cr = PIX_W'($urandom);
    case ($urandom_range(0, 3))
      0: p.a = 0;
      1: p.a = 4096;
      default: p.a = ALPHA_W'($urandom_range(0, 4096));
    endcase
    return p;
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send(bit o, int unsigned idx, pixel_t p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1;
    op <= o;
    index <= IDX_W'(idx);
    luma_in <= p.y; blue_diff_in <= p.cb; red_diff_in <= p.cr; alpha_in <= p.a;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic request(int unsigned idx);
    int unsigned n0, n1;
    sb.neighbors(idx, n0, n1);
    if (!sb.written[n0]) send(OP_WRITE, n0, random_pixel());
    if (!sb.written[n1]) send(OP_WRITE, n1, random_pixel());
    send(OP_REQUEST, idx, random_pixel());
  endtask

  task automatic write_reg(logic [0:0] reg_sel, int unsigned v);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {reg_sel, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (reg_sel == REG_STEP) sb.step_val = v & 24'hffffff;
    else sb.last_val = v & 12'hfff;
  endtask

  task automatic configure(int unsigned step_v, int unsigned last_v);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_STEP, step_v);
    write_reg(REG_LAST, last_v);
  endtask

  initial begin
    pixel_t p;
    int count;
    int unsigned idx, hi;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    p.y = 32767; p.cb = -32768; p.cr = 0; p.a = 4096;
    send(OP_WRITE, 0, p);
    p.y = -32768; p.cb = 32767; p.cr = -1; p.a = 4096;
    send(OP_WRITE, 1, p);
    p.y = 5; p.cb = -5; p.cr = 7; p.a = 0;
    send(OP_WRITE, 2, p);
    send(OP_WRITE, 3, p);
    p.y = 1; p.cb = 2; p.cr = 3; p.a = 4096;
    send(OP_WRITE, 4095, p);
    p.a = 4095;
    send(OP_WRITE, 4094, p);
    request(0);
    request(1);
    request(2);
    request(4095);
    request(4094);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: configure(1, 0);
        2: configure(16777215, 4095);
        3: configure($urandom_range(20000, 200000), 15);
        4: configure($urandom_range(32768, 40000), 255);
        default: configure($urandom_range(1, 16777215), $urandom_range(0, 4095));
      endcase
      if (ph < 2) begin
        send_idle_pct = 13; recv_idle_pct = 88;
      end else if (ph < 4) begin
        send_idle_pct = 88; recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (ph == 2) begin
        send_idle_pct = 0;
        phase = 2;
      end
      count = sent;
      while (sent - count < PHASE_ITEMS) begin
        if (ph == 2 && sent - count >= 40) send_idle_pct = 88;
        hi = (sb.last_val + 2 > DEPTH - 1) ? DEPTH - 1 : sb.last_val + 2;
        if ($urandom_range(0, 99) < 65) begin
          idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, hi) : $urandom_range(0, 4095);
          request(idx);
        end else begin
          idx = ($urandom_range(0, 1) != 0) ? $urandom_range(0, hi) : $urandom_range(0, 4095);
          send(OP_WRITE, idx, random_pixel());
        end
      end
    end

    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && sb.pending.size() == 0)
      $display("tb_alpha_weighted_linear_resample_core passed");
    else
      $display("tb_alpha_weighted_linear_resample_core failed");
    $finish;
  end

endmodule
